[sv/rcs_pkg.sv]
// Shared constants, types and register codes for the RC stick shaper.
package rcs_pkg;

    localparam int PULSE_W = 12;
    localparam int BAND_W = 8;
    localparam int REV_W = 3;
    localparam int EXPO_W = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    localparam int unsigned FULL_DEFLECTION_DEF = 500;
    localparam int unsigned OUTPUT_SPAN_DEF = 30;

    localparam int DEV_LIMIT = 1000;
    localparam int MAG_W = $clog2(DEV_LIMIT + 1);
    localparam int EXPO_ONE = 256;
    localparam int EXPO_MIN = 3;
    localparam int CMD_LIMIT = 61440;
    localparam int Q_W = $clog2(CMD_LIMIT + 1);
    localparam int CMD_W = Q_W + 1;

    localparam int DIV_FIRST = 9;
    localparam int DIV_STAGES = 4;
    localparam int LANE_STAGES = DIV_FIRST + DIV_STAGES;

    localparam logic [PULSE_W-1:0] CENTER_RST = PULSE_W'(1500);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROLL_CENTER  = 3'd0,
        CFG_PITCH_CENTER = 3'd1,
        CFG_YAW_CENTER   = 3'd2,
        CFG_AXIS_BAND    = 3'd3,
        CFG_YAW_BAND     = 3'd4,
        CFG_REVERSE      = 3'd5,
        CFG_EXPO         = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic           sat;
        logic           neg;
        logic [Q_W-1:0] quo;
    } t_lane_res;

endpackage

[sv/rcs_lane.sv]
// One axis lane: deviation, deadband, reverse, expo curve and pipelined divider.
module rcs_lane #(
    parameter int unsigned FULL_DEFLECTION = rcs_pkg::FULL_DEFLECTION_DEF,
    parameter int unsigned OUTPUT_SPAN = rcs_pkg::OUTPUT_SPAN_DEF
) (
    input  logic                                 i_clk,
    input  logic [rcs_pkg::LANE_STAGES-1:0]      i_en,
    input  logic [rcs_pkg::PULSE_W-1:0]          i_pulse,
    input  logic [rcs_pkg::PULSE_W-1:0]          i_center,
    input  logic [rcs_pkg::BAND_W-1:0]           i_band,
    input  logic                                 i_rev,
    input  logic [rcs_pkg::EXPO_W-1:0]           i_expo,
    output rcs_pkg::t_lane_res                   o_res
);

    localparam int PW = rcs_pkg::PULSE_W;
    localparam int MW = rcs_pkg::MAG_W;
    localparam int QW = rcs_pkg::Q_W;
    localparam int DF = rcs_pkg::DIV_FIRST;
    localparam int LS = rcs_pkg::LANE_STAGES;

    localparam longint unsigned DL = longint'(rcs_pkg::DEV_LIMIT);
    localparam longint unsigned F2 = longint'(FULL_DEFLECTION) * longint'(FULL_DEFLECTION);
    localparam longint unsigned F3 = F2 * longint'(FULL_DEFLECTION);
    localparam longint unsigned HALF = F3 / 2;
    localparam longint unsigned SQ_MAX = DL * DL;
    localparam longint unsigned CUBE_MAX = SQ_MAX * DL;
    localparam longint unsigned LIN_MAX = DL * F2;
    localparam longint unsigned ONE = longint'(rcs_pkg::EXPO_ONE);
    localparam longint unsigned T1_MAX = ONE * CUBE_MAX;
    localparam longint unsigned T2_MAX = ONE * LIN_MAX;
    localparam longint unsigned SUM_MAX = (T1_MAX > T2_MAX) ? T1_MAX : T2_MAX;
    localparam longint unsigned NUM_MAX = SUM_MAX * longint'(OUTPUT_SPAN);

    localparam int SQ_W = $clog2(SQ_MAX + 1);
    localparam int CUBE_W = $clog2(CUBE_MAX + 1);
    localparam int LIN_W = $clog2(LIN_MAX + 1);
    localparam int T1_W = $clog2(T1_MAX + 1);
    localparam int T2_W = $clog2(T2_MAX + 1);
    localparam int SUM_W = $clog2(SUM_MAX + 1);
    localparam int NUM_W = $clog2(NUM_MAX + 1);
    localparam int DEN_W = $clog2(F3 + 1);
    localparam int REM_NEED = $clog2(NUM_MAX + HALF + 1);
    localparam int R_W = (REM_NEED > DEN_W + QW) ? REM_NEED : DEN_W + QW;
    localparam logic [R_W-1:0] SAT_LIM = R_W'(F3) << QW;

    localparam int K = DEN_W + QW;
    localparam longint unsigned RCP = (longint'(1) << K) / F3;
    localparam int RCP_W = $clog2(RCP + 1);
    localparam int SPL = R_W / 2;
    localparam int PLO_W = SPL + RCP_W;
    localparam int PHI_W = R_W - SPL + RCP_W;
    localparam int EST_W = R_W + RCP_W;
    localparam int RMD_W = DEN_W + 1;

    logic signed [PW:0]      r_dev;
    logic [PW-1:0]           r_abs;
    logic                    r_sgn;
    logic [PW-1:0]           n_shr;
    logic [MW-1:0]           r_mag;
    logic [MW-1:0]           r_mag3;
    logic [SQ_W-1:0]         r_sq;
    logic [LIN_W-1:0]        r_lin;
    logic [LIN_W-1:0]        r_lin4;
    logic [CUBE_W-1:0]       r_cube;
    logic [T1_W-1:0]         r_t1;
    logic [T2_W-1:0]         r_t2;
    logic [SUM_W-1:0]        r_sum;
    logic [NUM_W-1:0]        r_num;
    logic [R_W-1:0]          r_rem8;
    logic                    r_neg [2:LS-1];
    logic                    r_sat [DF:LS-1];
    logic [PLO_W-1:0]        r_plo;
    logic [PHI_W-1:0]        r_phi;
    logic [R_W-1:0]          r_dvd;
    logic [R_W-1:0]          r_dvd2;
    logic [EST_W-1:0]        n_est_sum;
    logic [QW-1:0]           r_est;
    logic [QW-1:0]           r_est2;
    logic [RMD_W-1:0]        r_rmd;
    logic [QW-1:0]           r_quo;

    always_comb begin
        n_shr = (r_abs > PW'(i_band)) ? r_abs - PW'(i_band) : '0;
    end

    always_comb begin
        n_est_sum = (EST_W'(r_phi) << SPL) + EST_W'(r_plo);
    end

    // Division by the cube of full deflection: a reciprocal estimate that is low by at most
    // one, then a remainder check that corrects it.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_dev <= $signed({1'b0, i_pulse}) - $signed({1'b0, i_center});
        end
        if (i_en[1]) begin
            r_abs <= r_dev[PW] ? PW'(-r_dev) : PW'(r_dev);
            r_sgn <= r_dev[PW];
        end
        if (i_en[2]) begin
            r_mag <= (n_shr > PW'(rcs_pkg::DEV_LIMIT)) ? MW'(rcs_pkg::DEV_LIMIT) : MW'(n_shr);
            r_neg[2] <= r_sgn ^ i_rev;
        end
        if (i_en[3]) begin
            r_sq <= SQ_W'(r_mag) * SQ_W'(r_mag);
            r_lin <= LIN_W'(r_mag) * LIN_W'(F2);
            r_mag3 <= r_mag;
        end
        if (i_en[4]) begin
            r_cube <= CUBE_W'(r_sq) * CUBE_W'(r_mag3);
            r_lin4 <= r_lin;
        end
        if (i_en[5]) begin
            r_t1 <= T1_W'(i_expo) * T1_W'(r_cube);
            r_t2 <= T2_W'(rcs_pkg::EXPO_W'(rcs_pkg::EXPO_ONE) - i_expo) * T2_W'(r_lin4);
        end
        if (i_en[6]) begin
            r_sum <= SUM_W'(r_t1) + SUM_W'(r_t2);
        end
        if (i_en[7]) begin
            r_num <= NUM_W'(r_sum) * NUM_W'(OUTPUT_SPAN);
        end
        if (i_en[8]) begin
            r_rem8 <= R_W'(r_num) + R_W'(HALF);
        end
        if (i_en[DF]) begin
            r_sat[DF] <= (r_rem8 >= SAT_LIM);
            r_plo <= PLO_W'(r_rem8[SPL-1:0]) * PLO_W'(RCP);
            r_phi <= PHI_W'(r_rem8[R_W-1:SPL]) * PHI_W'(RCP);
            r_dvd <= r_rem8;
        end
        if (i_en[DF+1]) begin
            r_sat[DF+1] <= r_sat[DF];
            r_est <= n_est_sum[K +: QW];
            r_dvd2 <= r_dvd;
        end
        if (i_en[DF+2]) begin
            r_sat[DF+2] <= r_sat[DF+1];
            r_rmd <= RMD_W'(r_dvd2 - R_W'(r_est) * R_W'(F3));
            r_est2 <= r_est;
        end
        if (i_en[DF+3]) begin
            r_sat[DF+3] <= r_sat[DF+2];
            r_quo <= (r_rmd >= RMD_W'(F3)) ? r_est2 + QW'(1) : r_est2;
        end
    end

    for (genvar k = 3; k < LS; k++) begin : g_neg
        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    assign o_res.sat = r_sat[LS-1];
    assign o_res.neg = r_neg[LS-1];
    assign o_res.quo = r_quo;

endmodule

[sv/rcs_merge.sv]
// Output stage: clamps and signs the three lane results and holds the result beat.
module rcs_merge (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 i_out_ready,
    input  rcs_pkg::t_lane_res                   i_roll,
    input  rcs_pkg::t_lane_res                   i_pitch,
    input  rcs_pkg::t_lane_res                   i_yaw,
    input  logic [rcs_pkg::PULSE_W-1:0]          i_throttle,
    output logic                                 o_load,
    output logic                                 o_out_valid,
    output logic signed [rcs_pkg::CMD_W-1:0]     o_roll_command,
    output logic signed [rcs_pkg::CMD_W-1:0]     o_pitch_command,
    output logic [rcs_pkg::PULSE_W-1:0]          o_throttle_out,
    output logic signed [rcs_pkg::CMD_W-1:0]     o_yaw_command
);

    localparam int QW = rcs_pkg::Q_W;

    function automatic logic signed [rcs_pkg::CMD_W-1:0] f_cmd(rcs_pkg::t_lane_res r);
        logic [QW-1:0] q;
        q = (r.sat || (r.quo > QW'(rcs_pkg::CMD_LIMIT))) ? QW'(rcs_pkg::CMD_LIMIT) : r.quo;
        return r.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    logic                                 r_valid;
    logic signed [rcs_pkg::CMD_W-1:0]     r_roll;
    logic signed [rcs_pkg::CMD_W-1:0]     r_pitch;
    logic signed [rcs_pkg::CMD_W-1:0]     r_yaw;
    logic [rcs_pkg::PULSE_W-1:0]          r_thr;
    logic signed [rcs_pkg::CMD_W-1:0]     n_roll;
    logic signed [rcs_pkg::CMD_W-1:0]     n_pitch;
    logic signed [rcs_pkg::CMD_W-1:0]     n_yaw;

    assign o_load = !r_valid || i_out_ready;

    always_comb begin
        n_roll = f_cmd(i_roll);
        n_pitch = f_cmd(i_pitch);
        n_yaw = f_cmd(i_yaw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_roll <= n_roll;
            r_pitch <= n_pitch;
            r_yaw <= n_yaw;
            r_thr <= i_throttle;
        end
    end

    assign o_out_valid = r_valid;
    assign o_roll_command = r_roll;
    assign o_pitch_command = r_pitch;
    assign o_yaw_command = r_yaw;
    assign o_throttle_out = r_thr;

endmodule

[sv/rc_stick_shaper.sv]
// Top level of the RC stick shaper: configuration, pipeline control and the three axis lanes.
// The shaper takes one receiver frame per clock while the output side keeps up and returns
// it when the output side is ready: the roll, pitch and yaw lanes each run nine arithmetic stages
// followed by a four-stage division by reciprocal multiplication with a remainder check,
// and a final register merges the lanes with the throttle value. Each stage holds its beat
// only while the next one is full, so empty stages close up and a new frame is accepted
// whenever the first stage can move.
// Configuration writes take effect at once and are meant for times when no frame is in flight.
module rc_stick_shaper #(
    parameter int unsigned FULL_DEFLECTION = rcs_pkg::FULL_DEFLECTION_DEF,
    parameter int unsigned OUTPUT_SPAN = rcs_pkg::OUTPUT_SPAN_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rcs_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [rcs_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [rcs_pkg::PULSE_W-1:0]          i_roll_pulse,
    input  logic [rcs_pkg::PULSE_W-1:0]          i_pitch_pulse,
    input  logic [rcs_pkg::PULSE_W-1:0]          i_throttle_pulse_in,
    input  logic [rcs_pkg::PULSE_W-1:0]          i_yaw_pulse,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [rcs_pkg::CMD_W-1:0]     o_roll_command,
    output logic signed [rcs_pkg::CMD_W-1:0]     o_pitch_command,
    output logic [rcs_pkg::PULSE_W-1:0]          o_throttle_out,
    output logic signed [rcs_pkg::CMD_W-1:0]     o_yaw_command
);

    localparam int LS = rcs_pkg::LANE_STAGES;
    localparam int PW = rcs_pkg::PULSE_W;
    localparam int EW = rcs_pkg::EXPO_W;

    logic [PW-1:0]                 r_roll_center;
    logic [PW-1:0]                 r_pitch_center;
    logic [PW-1:0]                 r_yaw_center;
    logic [rcs_pkg::BAND_W-1:0]    r_axis_band;
    logic [rcs_pkg::BAND_W-1:0]    r_yaw_band;
    logic [rcs_pkg::REV_W-1:0]     r_reverse;
    logic [EW-1:0]                 r_expo;
    logic [EW-1:0]                 expo_eff;

    logic [LS-1:0]                 r_vld;
    logic [LS:0]                   stage_en;
    logic [PW-1:0]                 r_thr [LS];
    logic                          merge_load;
    rcs_pkg::t_lane_res            roll_res;
    rcs_pkg::t_lane_res            pitch_res;
    rcs_pkg::t_lane_res            yaw_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_center <= rcs_pkg::CENTER_RST;
            r_pitch_center <= rcs_pkg::CENTER_RST;
            r_yaw_center <= rcs_pkg::CENTER_RST;
            r_axis_band <= '0;
            r_yaw_band <= '0;
            r_reverse <= '0;
            r_expo <= '0;
        end else if (i_cfg_we) begin
            case (rcs_pkg::t_cfg_idx'(i_cfg_idx))
                rcs_pkg::CFG_ROLL_CENTER: begin
                    r_roll_center <= i_cfg_data[PW-1:0];
                end
                rcs_pkg::CFG_PITCH_CENTER: begin
                    r_pitch_center <= i_cfg_data[PW-1:0];
                end
                rcs_pkg::CFG_YAW_CENTER: begin
                    r_yaw_center <= i_cfg_data[PW-1:0];
                end
                rcs_pkg::CFG_AXIS_BAND: begin
                    r_axis_band <= i_cfg_data[rcs_pkg::BAND_W-1:0];
                end
                rcs_pkg::CFG_YAW_BAND: begin
                    r_yaw_band <= i_cfg_data[rcs_pkg::BAND_W-1:0];
                end
                rcs_pkg::CFG_REVERSE: begin
                    r_reverse <= i_cfg_data[rcs_pkg::REV_W-1:0];
                end
                rcs_pkg::CFG_EXPO: begin
                    r_expo <= i_cfg_data[EW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Small weights turn the curve off, and weights past one saturate to one.
    always_comb begin
        if (r_expo < EW'(rcs_pkg::EXPO_MIN)) begin
            expo_eff = '0;
        end else if (r_expo > EW'(rcs_pkg::EXPO_ONE)) begin
            expo_eff = EW'(rcs_pkg::EXPO_ONE);
        end else begin
            expo_eff = r_expo;
        end
    end

    assign stage_en[LS] = merge_load;
    for (genvar k = 0; k < LS; k++) begin : g_ctl
        assign stage_en[k] = !r_vld[k] || stage_en[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (stage_en[k]) begin
                r_vld[k] <= (k == 0) ? i_in_valid : r_vld[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (stage_en[k]) begin
                r_thr[k] <= (k == 0) ? i_throttle_pulse_in : r_thr[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign o_in_ready = stage_en[0];

    rcs_lane #(
        .FULL_DEFLECTION(FULL_DEFLECTION),
        .OUTPUT_SPAN(OUTPUT_SPAN)
    ) u_roll (
        .i_clk(i_clk),
        .i_en(stage_en[LS-1:0]),
        .i_pulse(i_roll_pulse),
        .i_center(r_roll_center),
        .i_band(r_axis_band),
        .i_rev(r_reverse[0]),
        .i_expo(expo_eff),
        .o_res(roll_res)
    );

    rcs_lane #(
        .FULL_DEFLECTION(FULL_DEFLECTION),
        .OUTPUT_SPAN(OUTPUT_SPAN)
    ) u_pitch (
        .i_clk(i_clk),
        .i_en(stage_en[LS-1:0]),
        .i_pulse(i_pitch_pulse),
        .i_center(r_pitch_center),
        .i_band(r_axis_band),
        .i_rev(r_reverse[1]),
        .i_expo(expo_eff),
        .o_res(pitch_res)
    );

    rcs_lane #(
        .FULL_DEFLECTION(FULL_DEFLECTION),
        .OUTPUT_SPAN(OUTPUT_SPAN)
    ) u_yaw (
        .i_clk(i_clk),
        .i_en(stage_en[LS-1:0]),
        .i_pulse(i_yaw_pulse),
        .i_center(r_yaw_center),
        .i_band(r_yaw_band),
        .i_rev(r_reverse[2]),
        .i_expo(expo_eff),
        .o_res(yaw_res)
    );

    rcs_merge u_merge (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_vld[LS-1]),
        .i_out_ready(i_out_ready),
        .i_roll(roll_res),
        .i_pitch(pitch_res),
        .i_yaw(yaw_res),
        .i_throttle(r_thr[LS-1]),
        .o_load(merge_load),
        .o_out_valid(o_out_valid),
        .o_roll_command(o_roll_command),
        .o_pitch_command(o_pitch_command),
        .o_throttle_out(o_throttle_out),
        .o_yaw_command(o_yaw_command)
    );

endmodule

[sv/rcs_check.sv]
// Port-level checks for the RC stick shaper, bound to the top level.
module rcs_check (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rcs_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [rcs_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    input  logic                                 o_in_ready,
    input  logic [rcs_pkg::PULSE_W-1:0]          i_roll_pulse,
    input  logic [rcs_pkg::PULSE_W-1:0]          i_pitch_pulse,
    input  logic [rcs_pkg::PULSE_W-1:0]          i_throttle_pulse_in,
    input  logic [rcs_pkg::PULSE_W-1:0]          i_yaw_pulse,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    input  logic signed [rcs_pkg::CMD_W-1:0]     o_roll_command,
    input  logic signed [rcs_pkg::CMD_W-1:0]     o_pitch_command,
    input  logic [rcs_pkg::PULSE_W-1:0]          o_throttle_out,
    input  logic signed [rcs_pkg::CMD_W-1:0]     o_yaw_command
);

    // After a reset cycle the output side is empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat present right after reset");

    // An empty output register means every stage can move, so the input must be open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input closed while output side is empty");

    // Commands never leave the saturation range.
    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_roll_command) <= rcs_pkg::CMD_LIMIT)
            && ($signed(o_roll_command) >= -rcs_pkg::CMD_LIMIT)
            && ($signed(o_pitch_command) <= rcs_pkg::CMD_LIMIT)
            && ($signed(o_pitch_command) >= -rcs_pkg::CMD_LIMIT)
            && ($signed(o_yaw_command) <= rcs_pkg::CMD_LIMIT)
            && ($signed(o_yaw_command) >= -rcs_pkg::CMD_LIMIT))
        else $error("command outside saturation range");

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_roll_command)
            && $stable(o_pitch_command) && $stable(o_yaw_command) && $stable(o_throttle_out))
        else $error("stalled result beat changed");

endmodule

bind rc_stick_shaper rcs_check u_rcs_check (.*);

[test/rcs_checker.sv]
`timescale 1ns / 1ps
// Checker for the RC stick shaper: mirrors the registers, predicts each frame and compares.
module rcs_checker
    import rcs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [PULSE_W-1:0]      i_roll_pulse,
    input  logic [PULSE_W-1:0]      i_pitch_pulse,
    input  logic [PULSE_W-1:0]      i_throttle_pulse_in,
    input  logic [PULSE_W-1:0]      i_yaw_pulse,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic signed [CMD_W-1:0] i_roll_command,
    input  logic signed [CMD_W-1:0] i_pitch_command,
    input  logic [PULSE_W-1:0]      i_throttle_out,
    input  logic signed [CMD_W-1:0] i_yaw_command,
    output int                      o_error_count,
    output int                      o_frames_pending
);

    typedef struct {
        logic signed [CMD_W-1:0] roll;
        logic signed [CMD_W-1:0] pitch;
        logic [PULSE_W-1:0]      throttle;
        logic signed [CMD_W-1:0] yaw;
    } t_shaped_frame;

    logic [PULSE_W-1:0] roll_ctr = CENTER_RST;
    logic [PULSE_W-1:0] pitch_ctr = CENTER_RST;
    logic [PULSE_W-1:0] yaw_ctr = CENTER_RST;
    logic [BAND_W-1:0]  stick_band = '0;
    logic [BAND_W-1:0]  yaw_dead = '0;
    logic [REV_W-1:0]   rev_bits = '0;
    logic [EXPO_W-1:0]  expo_wt = '0;

    t_shaped_frame shaped_q[$];
    t_shaped_frame want;

    task automatic report_error(input string msg);
        if (o_error_count < 100) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
        o_error_count++;
    endtask

    function automatic logic signed [CMD_W-1:0] shape_stick(
        input logic [PULSE_W-1:0] pulse,
        input logic [PULSE_W-1:0] center,
        input logic [BAND_W-1:0]  band,
        input logic               rev
    );
        int                dev;
        int                b;
        logic              neg;
        longint unsigned   wt;
        longint unsigned   mag;
        longint unsigned   f;
        longint unsigned   f2;
        longint unsigned   num;
        longint unsigned   den;
        longint unsigned   q;
        int                cmd;
        b = int'(band);
        dev = int'(pulse) - int'(center);
        if (dev > -b && dev < b) begin
            dev = 0;
        end else if (dev >= b) begin
            dev = dev - b;
        end else begin
            dev = dev + b;
        end
        if (rev) begin
            dev = -dev;
        end
        if (dev > DEV_LIMIT) begin
            dev = DEV_LIMIT;
        end
        if (dev < -DEV_LIMIT) begin
            dev = -DEV_LIMIT;
        end
        wt = longint'(expo_wt);
        if (wt > EXPO_ONE) begin
            wt = EXPO_ONE;
        end
        if (wt < EXPO_MIN) begin
            wt = 0;
        end
        neg = dev < 0;
        mag = neg ? longint'(-dev) : longint'(dev);
        f = FULL_DEFLECTION_DEF;
        f2 = f * f;
        num = (wt * mag * mag * mag + (EXPO_ONE - wt) * mag * f2) * OUTPUT_SPAN_DEF;
        den = f2 * f;
        q = (num + den / 2) / den;
        if (q > CMD_LIMIT) begin
            q = CMD_LIMIT;
        end
        cmd = neg ? -int'(q) : int'(q);
        return CMD_W'(cmd);
    endfunction

    function automatic t_shaped_frame shape_frame(
        input logic [PULSE_W-1:0] roll,
        input logic [PULSE_W-1:0] pitch,
        input logic [PULSE_W-1:0] throttle,
        input logic [PULSE_W-1:0] yaw
    );
        t_shaped_frame fr;
        fr.roll = shape_stick(roll, roll_ctr, stick_band, rev_bits[0]);
        fr.pitch = shape_stick(pitch, pitch_ctr, stick_band, rev_bits[1]);
        fr.throttle = throttle;
        fr.yaw = shape_stick(yaw, yaw_ctr, yaw_dead, rev_bits[2]);
        return fr;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            roll_ctr = CENTER_RST;
            pitch_ctr = CENTER_RST;
            yaw_ctr = CENTER_RST;
            stick_band = '0;
            yaw_dead = '0;
            rev_bits = '0;
            expo_wt = '0;
            shaped_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROLL_CENTER: roll_ctr = i_cfg_data[PULSE_W-1:0];
                    CFG_PITCH_CENTER: pitch_ctr = i_cfg_data[PULSE_W-1:0];
                    CFG_YAW_CENTER: yaw_ctr = i_cfg_data[PULSE_W-1:0];
                    CFG_AXIS_BAND: stick_band = i_cfg_data[BAND_W-1:0];
                    CFG_YAW_BAND: yaw_dead = i_cfg_data[BAND_W-1:0];
                    CFG_REVERSE: rev_bits = i_cfg_data[REV_W-1:0];
                    CFG_EXPO: expo_wt = i_cfg_data[EXPO_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                shaped_q.push_back(shape_frame(i_roll_pulse, i_pitch_pulse,
                                               i_throttle_pulse_in, i_yaw_pulse));
            end
            if (i_out_valid && i_out_ready) begin
                if (shaped_q.size() == 0) begin
                    report_error("output beat with no frame outstanding");
                end else begin
                    want = shaped_q.pop_front();
                    if (i_roll_command !== want.roll) begin
                        report_error($sformatf("roll_command expected %0d got %0d",
                                               want.roll, i_roll_command));
                    end
                    if (i_pitch_command !== want.pitch) begin
                        report_error($sformatf("pitch_command expected %0d got %0d",
                                               want.pitch, i_pitch_command));
                    end
                    if (i_throttle_out !== want.throttle) begin
                        report_error($sformatf("throttle_out expected %0d got %0d",
                                               want.throttle, i_throttle_out));
                    end
                    if (i_yaw_command !== want.yaw) begin
                        report_error($sformatf("yaw_command expected %0d got %0d",
                                               want.yaw, i_yaw_command));
                    end
                end
            end
        end
        o_frames_pending = shaped_q.size();
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Top of the RC stick shaper testbench: clock, reset, stimulus, stall patterns and verdict.
module tb_top;
    import rcs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SEGMENTS = 5;
    localparam int FRAMES_PER_SEGMENT = 129;
    localparam int STALL_CYCLES = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [PULSE_W-1:0] roll_pulse = '0;
    logic [PULSE_W-1:0] pitch_pulse = '0;
    logic [PULSE_W-1:0] throttle_pulse = '0;
    logic [PULSE_W-1:0] yaw_pulse = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [CMD_W-1:0] roll_cmd;
    logic signed [CMD_W-1:0] pitch_cmd;
    logic [PULSE_W-1:0] throttle_out;
    logic signed [CMD_W-1:0] yaw_cmd;

    int error_count;
    int frames_pending;
    int tx_idle_pct = 15;
    int rx_idle_pct = 85;
    int rx_hold_left = 0;
    int cycle_count = 0;

    int roll_ctr_now = 1500;
    int pitch_ctr_now = 1500;
    int yaw_ctr_now = 1500;
    int axis_band_now = 0;
    int yaw_band_now = 0;

    always #1 i_clk = ~i_clk;

    rc_stick_shaper u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_idx           (cfg_idx),
        .i_cfg_data          (cfg_data),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_roll_pulse        (roll_pulse),
        .i_pitch_pulse       (pitch_pulse),
        .i_throttle_pulse_in (throttle_pulse),
        .i_yaw_pulse         (yaw_pulse),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_roll_command      (roll_cmd),
        .o_pitch_command     (pitch_cmd),
        .o_throttle_out      (throttle_out),
        .o_yaw_command       (yaw_cmd)
    );

    rcs_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_idx           (cfg_idx),
        .i_cfg_data          (cfg_data),
        .i_in_valid          (in_valid),
        .i_in_ready          (in_ready),
        .i_roll_pulse        (roll_pulse),
        .i_pitch_pulse       (pitch_pulse),
        .i_throttle_pulse_in (throttle_pulse),
        .i_yaw_pulse         (yaw_pulse),
        .i_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .i_roll_command      (roll_cmd),
        .i_pitch_command     (pitch_cmd),
        .i_throttle_out      (throttle_out),
        .i_yaw_command       (yaw_cmd),
        .o_error_count       (error_count),
        .o_frames_pending    (frames_pending)
    );

    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            out_ready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            out_ready <= (int'($urandom_range(99)) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_frame(
        input logic [PULSE_W-1:0] roll,
        input logic [PULSE_W-1:0] pitch,
        input logic [PULSE_W-1:0] throttle,
        input logic [PULSE_W-1:0] yaw
    );
        @(negedge i_clk);
        while (int'($urandom_range(99)) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        roll_pulse <= roll;
        pitch_pulse <= pitch;
        throttle_pulse <= throttle;
        yaw_pulse <= yaw;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (frames_pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] data
    );
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(input int style);
        logic [CFG_DATA_W-1:0] val [7];
        case (style)
            0: begin
                for (int i = 0; i < 3; i++) begin
                    val[i] = CFG_DATA_W'($urandom_range(1700, 1300));
                end
                val[3] = CFG_DATA_W'($urandom_range(40));
                val[4] = CFG_DATA_W'($urandom_range(80));
                val[5] = CFG_DATA_W'($urandom_range(7));
                val[6] = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(5))
                                                  : CFG_DATA_W'($urandom_range(300));
            end
            1: begin
                for (int i = 0; i < 7; i++) begin
                    val[i] = '0;
                end
            end
            2: begin
                val[0] = 12'd4095;
                val[1] = 12'd4095;
                val[2] = 12'd4095;
                val[3] = 12'd255;
                val[4] = 12'd255;
                val[5] = 12'd7;
                val[6] = 12'd256;
            end
            default: begin
                for (int i = 0; i < 7; i++) begin
                    val[i] = CFG_DATA_W'($urandom_range(4095));
                end
            end
        endcase
        write_reg(CFG_ROLL_CENTER, val[0]);
        write_reg(CFG_PITCH_CENTER, val[1]);
        write_reg(CFG_YAW_CENTER, val[2]);
        write_reg(CFG_AXIS_BAND, val[3]);
        write_reg(CFG_YAW_BAND, val[4]);
        write_reg(CFG_REVERSE, val[5]);
        write_reg(CFG_EXPO, val[6]);
        roll_ctr_now = int'(val[0]);
        pitch_ctr_now = int'(val[1]);
        yaw_ctr_now = int'(val[2]);
        axis_band_now = int'(val[3][BAND_W-1:0]);
        yaw_band_now = int'(val[4][BAND_W-1:0]);
    endtask

    // Most pulses land within reach of the center so that band, expo and clamp all matter.
    function automatic logic [PULSE_W-1:0] stick_pulse(input int center, input int band);
        int p;
        int span;
        span = band + 1100;
        case ($urandom_range(9))
            0: p = int'($urandom_range(4095));
            1: p = center + (($urandom_range(1) == 1) ? band : -band)
                   + int'($urandom_range(2)) - 1;
            default: p = center + int'($urandom_range(2 * span)) - span;
        endcase
        if (p < 0) begin
            p = 0;
        end
        if (p > 4095) begin
            p = 4095;
        end
        return PULSE_W'(p);
    endfunction

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_frame(12'd0, 12'd0, 12'd0, 12'd0);
        send_frame(12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send_frame(12'd1500, 12'd1500, 12'd1500, 12'd1500);
        send_frame(12'd2000, 12'd1000, 12'd1234, 12'd2500);
        send_frame(12'd500, 12'd2501, 12'd2048, 12'd1499);

        drain_results();
        write_reg(CFG_AXIS_BAND, 12'd20);
        write_reg(CFG_YAW_BAND, 12'd255);
        write_reg(CFG_REVERSE, 12'd5);
        write_reg(CFG_EXPO, 12'd256);
        send_frame(12'd1520, 12'd1480, 12'd0, 12'd1755);
        send_frame(12'd1521, 12'd1479, 12'd4095, 12'd1245);
        send_frame(12'd1519, 12'd1481, 12'd1, 12'd1756);
        send_frame(12'd0, 12'd4095, 12'd2, 12'd4095);

        drain_results();
        write_reg(CFG_REVERSE, 12'd2);
        write_reg(CFG_EXPO, 12'd2);
        send_frame(12'd1700, 12'd1300, 12'd3, 12'd1900);
        send_frame(12'd4095, 12'd0, 12'd4, 12'd0);
        drain_results();
        write_reg(CFG_EXPO, 12'd3);
        send_frame(12'd1700, 12'd1300, 12'd3, 12'd1900);
        send_frame(12'd4095, 12'd0, 12'd4, 12'd0);
        drain_results();
        write_reg(CFG_EXPO, 12'd511);
        send_frame(12'd1700, 12'd1300, 12'd3, 12'd1900);
        send_frame(12'd4095, 12'd0, 12'd4, 12'd0);

        drain_results();
        write_reg(CFG_UNUSED_IDX, 12'hFFF);
        write_reg(CFG_ROLL_CENTER, 12'd0);
        write_reg(CFG_PITCH_CENTER, 12'd4095);
        write_reg(CFG_YAW_CENTER, 12'hFFF);
        write_reg(CFG_AXIS_BAND, 12'hFFF);
        send_frame(12'd0, 12'd4095, 12'd5, 12'd2000);
        send_frame(12'd4095, 12'd0, 12'd6, 12'd0);
        send_frame(12'd1000, 12'd3095, 12'd7, 12'd1000);

        for (int r = 0; r < 3; r++) begin
            case (r)
                0: begin
                    tx_idle_pct = 15;
                    rx_idle_pct = 85;
                end
                1: begin
                    tx_idle_pct = 85;
                    rx_idle_pct = 15;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int s = 0; s < SEGMENTS; s++) begin
                drain_results();
                apply_settings((r * SEGMENTS + s) % 4);
                if (r == 2 && s == 0) begin
                    @(posedge i_clk);
                    rx_hold_left = STALL_CYCLES;
                end
                repeat (FRAMES_PER_SEGMENT) begin
                    send_frame(stick_pulse(roll_ctr_now, axis_band_now),
                               stick_pulse(pitch_ctr_now, axis_band_now),
                               PULSE_W'($urandom_range(4095)),
                               stick_pulse(yaw_ctr_now, yaw_band_now));
                end
            end
        end

        drain_results();
        repeat (LANE_STAGES + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
